// File: hw/rtl/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Shared types and constants for the dense slot table with handle recycling.
// ----------------------------------------------------------------------------
package dst_pkg;

  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 8;
  localparam int SLOT_W   = 8;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 2;
  localparam int LCNT_W   = 9;

  localparam int MAX_ENTRIES_DEF = 256;
  localparam int ENTRY_WIDTH_DEF = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SET    = 2'd2,
    KIND_GET    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle_out;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   data_out;
    logic [LCNT_W-1:0]   live_count;
  } res_t;

endpackage

// File: hw/rtl/dst_if.sv
// ----------------------------------------------------------------------------
// dst_if
// Request and result channels (valid/ready) of the dense slot table.
// ----------------------------------------------------------------------------
interface dst_in_if
  import dst_pkg::*;
  ();
  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [HANDLE_W-1:0] handle;
  logic [DATA_W-1:0]   entry_data;

  modport source (output valid, output kind, output handle, output entry_data, input ready);
  modport sink   (input valid, input kind, input handle, input entry_data, output ready);
endinterface

interface dst_out_if
  import dst_pkg::*;
  ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [HANDLE_W-1:0] handle_out;
  logic [SLOT_W-1:0]   slot;
  logic [DATA_W-1:0]   data_out;
  logic [LCNT_W-1:0]   live_count;

  modport source (output valid, output status, output handle_out, output slot,
                  output data_out, output live_count, input ready);
  modport sink   (input valid, input status, input handle_out, input slot,
                  input data_out, input live_count, output ready);
endinterface

// File: hw/rtl/dst_ram.sv
// ----------------------------------------------------------------------------
// dst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/dst_out_reg.sv
// ----------------------------------------------------------------------------
// dst_out_reg
// Result register: holds one finished result beat until the sink takes it.
// ----------------------------------------------------------------------------
module dst_out_reg
  import dst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  res_t      res,
  output logic      res_ready,
  dst_out_if.source out_ch
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign res_ready = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.status     = res_r.status;
  assign out_ch.handle_out = res_r.handle_out;
  assign out_ch.slot       = res_r.slot;
  assign out_ch.data_out   = res_r.data_out;
  assign out_ch.live_count = res_r.live_count;

endmodule

// File: hw/rtl/dense_slot_table_with_id_recycling.sv
// ----------------------------------------------------------------------------
// dense_slot_table_with_id_recycling
// Packed entry table addressed by stable handles; swap-remove on delete,
// LIFO recycling of freed handles.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   kind, handle, entry_data
//   out_ch   out  valid/ready   status, handle_out, slot, data_out, live_count
//
// One request beat at a time. Add passes S_POP (when the handle comes off the
// free stack) and S_ADD; set, get and remove pass S_LOOK and S_VERIFY, get and a
// moving remove then S_FETCH; rejects end early, and S_DONE waits out any stall
// on out_ch. The steps follow the chain of dependent lookups through the handle
// map, slot map and entry store, each a one-read RAM with registered read data.
// Synchronous active-low reset clears only counters and control; liveness
// is derived from the maps and the next-handle counter, so no clearing pass.
// A finished result waits in the output register while the next beat runs.
// ----------------------------------------------------------------------------
module dense_slot_table_with_id_recycling
  import dst_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dst_in_if.sink    in_ch,
  dst_out_if.source out_ch
);

  localparam int HW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_POP    = 7'b0000010,
    S_ADD    = 7'b0000100,
    S_LOOK   = 7'b0001000,
    S_VERIFY = 7'b0010000,
    S_FETCH  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  kind_t                 kind_r, kind_nxt;
  status_t               stat_r, stat_nxt;
  logic [HANDLE_W-1:0]   hin_r, hin_nxt;
  logic [HW-1:0]         hidx_r, hidx_nxt;
  logic [HW-1:0]         nh_r, nh_nxt;
  logic [HW-1:0]         slot_r, slot_nxt;
  logic [ENTRY_WIDTH-1:0] data_r, data_nxt;
  logic [ENTRY_WIDTH-1:0] dout_r, dout_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         ftop_r, ftop_nxt;
  logic [CW-1:0]         nhc_r, nhc_nxt;

  logic                  h2s_we, h2s_re, s2h_we, s2h_re, fs_we, fs_re, es_we, es_re;
  logic [HW-1:0]         h2s_waddr, h2s_raddr, h2s_wdata, h2s_rd;
  logic [HW-1:0]         s2h_waddr, s2h_raddr, s2h_wdata, s2h_rd;
  logic [HW-1:0]         fs_waddr, fs_raddr, fs_wdata, fs_rd;
  logic [HW-1:0]         es_waddr, es_raddr;
  logic [ENTRY_WIDTH-1:0] es_wdata, es_rd;

  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic                  full;

  assign in_ch.ready = (state_r == S_IDLE);
  assign full = (count_r == CW'(MAX_ENTRIES)) ||
                ((ftop_r == '0) && (nhc_r == CW'(MAX_ENTRIES)));

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    stat_nxt  = stat_r;
    hin_nxt   = hin_r;
    hidx_nxt  = hidx_r;
    nh_nxt    = nh_r;
    slot_nxt  = slot_r;
    data_nxt  = data_r;
    dout_nxt  = dout_r;
    count_nxt = count_r;
    ftop_nxt  = ftop_r;
    nhc_nxt   = nhc_r;
    h2s_we = 1'b0; h2s_re = 1'b0; h2s_waddr = '0; h2s_raddr = '0; h2s_wdata = '0;
    s2h_we = 1'b0; s2h_re = 1'b0; s2h_waddr = '0; s2h_raddr = '0; s2h_wdata = '0;
    fs_we  = 1'b0; fs_re  = 1'b0; fs_waddr  = '0; fs_raddr  = '0; fs_wdata  = '0;
    es_we  = 1'b0; es_re  = 1'b0; es_waddr  = '0; es_raddr  = '0; es_wdata  = '0;
    res_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt = in_ch.kind;
          hin_nxt  = in_ch.handle;
          hidx_nxt = HW'(in_ch.handle);
          data_nxt = in_ch.entry_data[ENTRY_WIDTH-1:0];
          dout_nxt = '0;
          slot_nxt = '0;
          nh_nxt   = '0;
          stat_nxt = ST_OK;
          if (in_ch.kind == KIND_ADD) begin
            if (full) begin
              stat_nxt  = ST_FULL;
              state_nxt = S_DONE;
            end else if (ftop_r != '0) begin
              fs_re     = 1'b1;
              fs_raddr  = HW'(ftop_r - CW'(1));
              ftop_nxt  = ftop_r - CW'(1);
              state_nxt = S_POP;
            end else begin
              nh_nxt    = HW'(nhc_r);
              nhc_nxt   = nhc_r + CW'(1);
              state_nxt = S_ADD;
            end
          end else if ((count_r == '0) || (32'(in_ch.handle) >= 32'(nhc_r))) begin
            stat_nxt  = ST_NOT_LIVE;
            state_nxt = S_DONE;
          end else begin
            h2s_re    = 1'b1;
            h2s_raddr = HW'(in_ch.handle);
            state_nxt = S_LOOK;
          end
        end
      end
      S_POP: begin
        nh_nxt    = fs_rd;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        es_we     = 1'b1;
        es_waddr  = HW'(count_r);
        es_wdata  = data_r;
        h2s_we    = 1'b1;
        h2s_waddr = nh_r;
        h2s_wdata = HW'(count_r);
        s2h_we    = 1'b1;
        s2h_waddr = HW'(count_r);
        s2h_wdata = nh_r;
        slot_nxt  = HW'(count_r);
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_LOOK: begin
        slot_nxt = h2s_rd;
        if (CW'(h2s_rd) >= count_r) begin
          stat_nxt  = ST_NOT_LIVE;
          state_nxt = S_DONE;
        end else begin
          s2h_re    = 1'b1;
          s2h_raddr = h2s_rd;
          state_nxt = S_VERIFY;
        end
      end
      S_VERIFY: begin
        if (s2h_rd != hidx_r) begin
          stat_nxt  = ST_NOT_LIVE;
          state_nxt = S_DONE;
        end else begin
          case (kind_r)
            KIND_SET: begin
              es_we     = 1'b1;
              es_waddr  = slot_r;
              es_wdata  = data_r;
              state_nxt = S_DONE;
            end
            KIND_GET: begin
              es_re     = 1'b1;
              es_raddr  = slot_r;
              state_nxt = S_FETCH;
            end
            KIND_REMOVE: begin
              fs_we     = 1'b1;
              fs_waddr  = HW'(ftop_r);
              fs_wdata  = hidx_r;
              ftop_nxt  = ftop_r + CW'(1);
              count_nxt = count_r - CW'(1);
              if (CW'(slot_r) != count_r - CW'(1)) begin
                // move the last entry into the freed slot
                es_re     = 1'b1;
                es_raddr  = HW'(count_r - CW'(1));
                s2h_re    = 1'b1;
                s2h_raddr = HW'(count_r - CW'(1));
                state_nxt = S_FETCH;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (kind_r == KIND_GET) begin
          dout_nxt = es_rd;
        end else begin
          es_we     = 1'b1;
          es_waddr  = slot_r;
          es_wdata  = es_rd;
          h2s_we    = 1'b1;
          h2s_waddr = s2h_rd;
          h2s_wdata = slot_r;
          s2h_we    = 1'b1;
          s2h_waddr = slot_r;
          s2h_wdata = s2h_rd;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status     = stat_r;
    res.slot       = (stat_r == ST_OK) ? SLOT_W'(slot_r) : '0;
    res.data_out   = DATA_W'(dout_r);
    res.live_count = LCNT_W'(count_r);
    if (kind_r == KIND_ADD) begin
      res.handle_out = (stat_r == ST_OK) ? HANDLE_W'(nh_r) : '0;
    end else begin
      res.handle_out = hin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ftop_r  <= '0;
      nhc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ftop_r  <= ftop_nxt;
      nhc_r   <= nhc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    stat_r <= stat_nxt;
    hin_r  <= hin_nxt;
    hidx_r <= hidx_nxt;
    nh_r   <= nh_nxt;
    slot_r <= slot_nxt;
    data_r <= data_nxt;
    dout_r <= dout_nxt;
  end

  dst_ram #(.WIDTH(HW), .DEPTH(MAX_ENTRIES)) u_h2s (
    .clk(clk), .we(h2s_we), .waddr(h2s_waddr), .wdata(h2s_wdata),
    .re(h2s_re), .raddr(h2s_raddr), .rdata(h2s_rd)
  );

  dst_ram #(.WIDTH(HW), .DEPTH(MAX_ENTRIES)) u_s2h (
    .clk(clk), .we(s2h_we), .waddr(s2h_waddr), .wdata(s2h_wdata),
    .re(s2h_re), .raddr(s2h_raddr), .rdata(s2h_rd)
  );

  dst_ram #(.WIDTH(HW), .DEPTH(MAX_ENTRIES)) u_free (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .re(fs_re), .raddr(fs_raddr), .rdata(fs_rd)
  );

  dst_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(MAX_ENTRIES)) u_entry (
    .clk(clk), .we(es_we), .waddr(es_waddr), .wdata(es_wdata),
    .re(es_re), .raddr(es_raddr), .rdata(es_rd)
  );

  dst_out_reg u_out (
    .clk(clk),
    .rst_n(rst_n),
    .res_valid(res_valid),
    .res(res),
    .res_ready(res_ready),
    .out_ch(out_ch)
  );

  // every issued handle is either live or on the free stack
  a_handle_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |->
      (({1'b0, count_r} + {1'b0, ftop_r}) == {1'b0, nhc_r}))
    else $error("handle count mismatch");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("live count above capacity");

  a_accept_starts_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE)
    else $error("accepted beat did not start an operation");

  a_done_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && res_ready |=> state_r == S_IDLE && $past(res_valid))
    else $error("result not handed to output register");

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dense slot table. A directed table drives the
// reset state, the data extremes, the handle-not-live cases, swap-remove and
// last-slot removal. After that, random fill and drain phases run the table up
// to capacity, where adds meet the table-full case, and back down. Each result
// beat is compared field by field against the row's own expected result or a
// behavioral copy of the table that the bench keeps. Both channels idle in
// random bursts, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb
  import dst_pkg::*;
();

  localparam int DEPTH     = MAX_ENTRIES_DEF;
  localparam int N_RAND    = 800;
  localparam int LONG_HOLD = 120;

  typedef struct {
    kind_t        kind;
    logic [7:0]   handle;
    logic [63:0]  data;
    bit           typed;
    res_t         want;
  } vec_t;

  logic clk;
  logic rst_n;

  dst_in_if  in_ch ();
  dst_out_if out_ch ();

  dense_slot_table_with_id_recycling u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // bench copy of the table
  logic [7:0]  slot_of  [DEPTH];
  logic [7:0]  owner_of [DEPTH];
  bit          is_live  [DEPTH];
  logic [7:0]  free_ids [DEPTH];
  logic [63:0] entries  [DEPTH];
  int          free_depth;
  int          fresh_id;
  int          live_n;

  res_t results_due [$];

  bit hold_req;
  bit calm;
  bit quiet;
  int n_bad;
  int n_checked;
  int n_kind [4];
  int n_full;
  int n_dead;
  int peak;

  vec_t dir_rows [22] = '{
    '{KIND_GET,    8'h00, 64'h0, 1'b1, '{ST_NOT_LIVE, 8'h00, 8'h00, 64'h0, 9'd0}},
    '{KIND_REMOVE, 8'hff, 64'h0, 1'b1, '{ST_NOT_LIVE, 8'hff, 8'h00, 64'h0, 9'd0}},
    '{KIND_SET,    8'h80, '1,    1'b1, '{ST_NOT_LIVE, 8'h80, 8'h00, 64'h0, 9'd0}},
    '{KIND_ADD,    8'hff, '1,    1'b1, '{ST_OK,       8'h00, 8'h00, 64'h0, 9'd1}},
    '{KIND_ADD,    8'h00, 64'h0, 1'b1, '{ST_OK,       8'h01, 8'h01, 64'h0, 9'd2}},
    '{KIND_ADD,    8'h5a, 64'h8000_0000_0000_0001, 1'b1,
      '{ST_OK, 8'h02, 8'h02, 64'h0, 9'd3}},
    '{KIND_GET,    8'h00, 64'h0, 1'b1, '{ST_OK,       8'h00, 8'h00, '1,    9'd3}},
    '{KIND_GET,    8'h01, 64'h0, 1'b1, '{ST_OK,       8'h01, 8'h01, 64'h0, 9'd3}},
    '{KIND_SET,    8'h01, 64'ha5a5_5a5a_0f0f_f0f0, 1'b0, '0},
    '{KIND_GET,    8'h01, 64'h0, 1'b0, '0},
    // swap-remove: handle 2 moves into slot 0
    '{KIND_REMOVE, 8'h00, 64'h0, 1'b1, '{ST_OK,       8'h00, 8'h00, 64'h0, 9'd2}},
    '{KIND_GET,    8'h02, 64'h0, 1'b0, '0},
    '{KIND_REMOVE, 8'h00, 64'h0, 1'b1, '{ST_NOT_LIVE, 8'h00, 8'h00, 64'h0, 9'd2}},
    '{KIND_ADD,    8'h3c, 64'h0123_4567_89ab_cdef, 1'b0, '0},
    // last slot, no move
    '{KIND_REMOVE, 8'h00, 64'h0, 1'b0, '0},
    '{KIND_SET,    8'h02, 64'h7fff_ffff_ffff_ffff, 1'b0, '0},
    '{KIND_GET,    8'h02, 64'h0, 1'b0, '0},
    '{KIND_REMOVE, 8'h02, 64'h0, 1'b0, '0},
    '{KIND_REMOVE, 8'h01, 64'h0, 1'b0, '0},
    '{KIND_GET,    8'h01, 64'h0, 1'b1, '{ST_NOT_LIVE, 8'h01, 8'h00, 64'h0, 9'd0}},
    '{KIND_ADD,    8'hc3, 64'hffff_0000_ffff_0000, 1'b0, '0},
    '{KIND_GET,    8'h01, 64'h0, 1'b0, '0}
  };

  function automatic res_t table_op_result(kind_t k, logic [7:0] h, logic [63:0] d);
    res_t r;
    int   s;
    int   last;
    int   nh;
    int   mv;
    r = '0;
    r.status = ST_OK;
    r.handle_out = h;
    if (k == KIND_ADD) begin
      if (live_n >= DEPTH || (free_depth == 0 && fresh_id >= DEPTH)) begin
        r.status = ST_FULL;
        r.handle_out = '0;
      end else begin
        s = live_n;
        if (free_depth > 0) begin
          free_depth--;
          nh = free_ids[free_depth];
        end else begin
          nh = fresh_id;
          fresh_id++;
        end
        live_n++;
        entries[s] = d;
        is_live[nh] = 1'b1;
        slot_of[nh] = 8'(s);
        owner_of[s] = 8'(nh);
        r.handle_out = 8'(nh);
        r.slot = 8'(s);
      end
    end else if (!is_live[h] || live_n == 0) begin
      r.status = ST_NOT_LIVE;
    end else begin
      s = slot_of[h];
      r.slot = 8'(s);
      if (k == KIND_REMOVE) begin
        last = live_n - 1;
        live_n = last;
        if (last != s) begin
          mv = owner_of[last];
          entries[s] = entries[last];
          slot_of[mv] = 8'(s);
          owner_of[s] = 8'(mv);
        end
        is_live[h] = 1'b0;
        if (free_depth < DEPTH) begin
          free_ids[free_depth] = h;
          free_depth++;
        end
      end else if (k == KIND_SET) begin
        entries[s] = d;
      end else begin
        r.data_out = entries[s];
      end
    end
    r.live_count = 9'(live_n);
    return r;
  endfunction

  task automatic send_beat(input kind_t k, input logic [7:0] h, input logic [63:0] d,
                           input bit typed, input res_t want);
    res_t r;
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= k;
    in_ch.handle     <= h;
    in_ch.entry_data <= d;
    do @(posedge clk); while (!in_ch.ready);
    r = table_op_result(k, h, d);
    n_kind[k]++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_NOT_LIVE) n_dead++;
    if (live_n > peak) peak = live_n;
    results_due.insert(results_due.size(), typed ? want : r);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.handle_out, out_ch.slot, out_ch.data_out,
              out_ch.live_count};
      if (results_due.size() == 0) begin
        $error("unexpected result beat: status %0d handle %0d", got.status, got.handle_out);
        n_bad++;
      end else begin
        want = results_due.pop_front();
        n_checked++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          n_bad++;
        end
        if (got.handle_out !== want.handle_out) begin
          $error("handle_out: expected %0d, got %0d", want.handle_out, got.handle_out);
          n_bad++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got.slot);
          n_bad++;
        end
        if (got.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, got.data_out);
          n_bad++;
        end
        if (got.live_count !== want.live_count) begin
          $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
          n_bad++;
        end
      end
    end
  end

  initial begin
    kind_t       k;
    logic [7:0]  h;
    logic [63:0] d;
    int          roll;
    bit          filling;
    int          full_streak;
    filling     = 1'b1;
    full_streak = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_ADD;
    in_ch.handle     <= '0;
    in_ch.entry_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].handle, dir_rows[i].data,
                dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < N_RAND; i++) begin
      calm  = ((i / 64) % 4) == 2;
      quiet = i >= N_RAND - 80;
      if (i == 300) hold_req = 1'b1;
      if (i == 480) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (results_due.size() != 0);
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end

      // fill to capacity, linger there, then drain back to empty
      if (live_n == DEPTH) full_streak++;
      if (filling && full_streak >= 6) begin
        filling     = 1'b0;
        full_streak = 0;
      end
      if (!filling && live_n == 0) filling = 1'b1;

      roll = $urandom_range(0, 99);
      h = 8'($urandom);
      d = {$urandom, $urandom};
      if ($urandom_range(0, 15) == 0) d = $urandom_range(0, 1) ? '1 : '0;
      if (roll < 5) begin
        k = kind_t'($urandom_range(0, 3));
      end else begin
        if (live_n > 0) h = owner_of[$urandom_range(0, live_n - 1)];
        if (roll < (filling ? 80 : 10) || live_n == 0) k = KIND_ADD;
        else if (roll < (filling ? 85 : 80)) k = KIND_REMOVE;
        else if (roll < 90) k = KIND_SET;
        else k = KIND_GET;
      end
      send_beat(k, h, d, 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d beats in (%0d add, %0d remove, %0d set, %0d get), %0d results checked",
             n_kind[0] + n_kind[1] + n_kind[2] + n_kind[3], n_kind[0], n_kind[1],
             n_kind[2], n_kind[3], n_checked);
    $display("tb: %0d table-full, %0d handle-not-live, peak of %0d live entries",
             n_full, n_dead, peak);
    if (n_bad == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
